// ----- design/vdtt_pkg.sv -----
// Shared types, codes and widths of the dual VIA timer block.
package vdtt_pkg;

	localparam int COUNTER_BITS = 16;
	localparam int CNT_W        = COUNTER_BITS + 2;
	localparam int TICK_W       = 8;
	localparam int VALUE_W      = 16;
	localparam int PERIOD_W     = 16;
	localparam int FILL_W       = 17;
	localparam int REG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_START_T1 = 2'd1;
	localparam logic [1:0] OP_START_T2 = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_T1_LATCH     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_T1_FREE_RUN  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_T1_PB7_EN    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_T2_PULSE     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_VSYNC_PERIOD = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_PERIOD = 3'd5;

	localparam logic [VALUE_W-1:0]    T1_LATCH_RST     = 16'hffff;
	localparam logic [PERIOD_W-1:0]   VSYNC_PERIOD_RST = 16'd20000;
	localparam logic [PERIOD_W-1:0]   FRAME_PERIOD_RST = 16'd40000;

	typedef logic [CNT_W-1:0] count_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [TICK_W-1:0]  cpu_ticks;
		logic [VALUE_W-1:0] start_value;
	} cmd_word_t;

	typedef struct packed {
		logic               pb7_level;
		logic               t1_fired;
		logic               t2_fired;
		logic               vsync_pulse;
		logic               frame_due;
		logic [VALUE_W-1:0] t1_now;
		logic [VALUE_W-1:0] t2_now;
	} res_word_t;

	typedef struct packed {
		logic [REG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
	} cfg_word_t;

endpackage

// ----- design/vdtt_if.sv -----
// Valid/ready channel interfaces for commands, results and register writes.
interface vdtt_cmd_if;
	logic                 valid;
	logic                 ready;
	vdtt_pkg::cmd_word_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface vdtt_res_if;
	logic                 valid;
	logic                 ready;
	vdtt_pkg::res_word_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface vdtt_cfg_if;
	logic                 valid;
	logic                 ready;
	vdtt_pkg::cfg_word_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- design/vdtt_period.sv -----
// Running tick accumulator that flags each elapsed period.
module vdtt_period (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [vdtt_pkg::TICK_W-1:0]   half,
	input  logic [vdtt_pkg::PERIOD_W-1:0] period,
	output logic                          hit
);
	import vdtt_pkg::*;

	logic [FILL_W-1:0] count_q;
	logic [FILL_W-1:0] sum;
	logic [FILL_W-1:0] count_d;

	always_comb begin
		sum = count_q + FILL_W'(half);
		hit = (sum >= FILL_W'(period));
		count_d = hit ? (sum - FILL_W'(period)) : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (step) begin
			count_q <= count_d;
		end
	end

endmodule

// ----- design/via_dual_timer_tick.sv -----
// Top level: two VIA timers, tick halving, vsync and frame-due counters.
// A word taken into the input register is processed into the result register when that register can advance.
// Throughput: one command word per cycle while the result side is not stalled; the state update is a single
//   pass of short adds and compares between the input register and the result register.
// Reset (arst_n low): all counters, carry and PB7 state clear to zero; registers
//   return to latch 0xffff, one-shot, PB7 off, pulse mode off, periods 20000/40000.
module via_dual_timer_tick (
	input  logic clk,
	input  logic arst_n,
	vdtt_cmd_if.sink   cmd,
	vdtt_res_if.source res,
	vdtt_cfg_if.sink   cfg
);
	import vdtt_pkg::*;

	localparam count_t WRAP_MASK = count_t'({COUNTER_BITS{1'b1}});

	// configuration registers
	logic [VALUE_W-1:0]  t1_latch_q;
	logic                t1_free_run_q;
	logic                t1_pb7_en_q;
	logic                t2_pulse_q;
	logic [PERIOD_W-1:0] vsync_period_q;
	logic [PERIOD_W-1:0] frame_period_q;

	// timer state
	logic   tick_carry_q;
	count_t t1_count_q;
	count_t t2_count_q;
	logic   pb7_armed_q;
	logic   pb7_state_q;
	logic   t2_armed_q;

	// input register and result register
	logic      v_s1;
	cmd_word_t cmd_s1;
	logic      v_s2;
	res_word_t res_s2;

	logic advance;
	logic proc;
	logic tick_op;

	assign advance   = !v_s2 || res.ready;
	assign proc      = v_s1 && advance;
	assign tick_op   = (cmd_s1.operation == OP_TICK);
	assign cmd.ready = !v_s1 || advance;
	assign cfg.ready = 1'b1;
	assign res.valid = v_s2;
	assign res.data  = res_s2;

	// register writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_latch_q     <= T1_LATCH_RST;
			t1_free_run_q  <= 1'b0;
			t1_pb7_en_q    <= 1'b0;
			t2_pulse_q     <= 1'b0;
			vsync_period_q <= VSYNC_PERIOD_RST;
			frame_period_q <= FRAME_PERIOD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				REG_T1_LATCH:     t1_latch_q     <= cfg.data.value;
				REG_T1_FREE_RUN:  t1_free_run_q  <= cfg.data.value[0];
				REG_T1_PB7_EN:    t1_pb7_en_q    <= cfg.data.value[0];
				REG_T2_PULSE:     t2_pulse_q     <= cfg.data.value[0];
				REG_VSYNC_PERIOD: vsync_period_q <= cfg.data.value;
				REG_FRAME_PERIOD: frame_period_q <= cfg.data.value;
				default: ;
			endcase
		end
	end

	// tick halving: 9-bit sum, odd tick carried into the next batch
	logic [TICK_W:0]   tick_sum;
	logic [TICK_W-1:0] half;
	assign tick_sum = {1'b0, cmd_s1.cpu_ticks} + {{TICK_W{1'b0}}, tick_carry_q};
	assign half     = tick_sum[TICK_W:1];

	logic vs_hit;
	logic fd_hit;

	vdtt_period u_vsync (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (proc && tick_op),
		.half   (half),
		.period (vsync_period_q),
		.hit    (vs_hit)
	);

	vdtt_period u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (proc && tick_op),
		.half   (half),
		.period (frame_period_q),
		.hit    (fd_hit)
	);

	// next-state logic
	count_t t1_dec, t2_dec;
	logic   t1_zero, t2_zero;
	count_t t1_count_d, t2_count_d;
	logic   pb7_armed_d, pb7_state_d, t2_armed_d, tick_carry_d;
	logic   t1_fire, t2_fire;

	assign t1_dec  = t1_count_q - count_t'(half);
	assign t2_dec  = t2_count_q - count_t'(half);
	// at or below zero: zero, or sign bit of the widened count set
	assign t1_zero = (t1_dec == '0) || t1_dec[CNT_W-1];
	assign t2_zero = (t2_dec == '0) || t2_dec[CNT_W-1];

	always_comb begin
		t1_count_d   = t1_count_q;
		t2_count_d   = t2_count_q;
		pb7_armed_d  = pb7_armed_q;
		pb7_state_d  = pb7_state_q;
		t2_armed_d   = t2_armed_q;
		tick_carry_d = tick_carry_q;
		t1_fire      = 1'b0;
		t2_fire      = 1'b0;
		unique case (cmd_s1.operation)
			OP_TICK: begin
				tick_carry_d = tick_sum[0];
				t1_count_d   = t1_dec;
				if (t1_zero) begin
					t1_fire = 1'b1;
					if (pb7_armed_q) begin
						if (t1_free_run_q) begin
							pb7_state_d = !pb7_state_q;
						end else begin
							pb7_state_d = 1'b1;
							pb7_armed_d = 1'b0;
						end
					end
					t1_count_d = t1_free_run_q ? (t1_dec + count_t'(t1_latch_q))
					                           : (t1_dec & WRAP_MASK);
				end
				// pulse-count mode freezes timer two here
				if (!t2_pulse_q) begin
					t2_count_d = t2_dec;
					if (t2_zero) begin
						t2_fire    = t2_armed_q;
						t2_armed_d = 1'b0;
						t2_count_d = t2_dec & WRAP_MASK;
					end
				end
			end
			OP_START_T1: begin
				t1_count_d  = count_t'(cmd_s1.start_value);
				pb7_armed_d = t1_pb7_en_q;
				if (t1_pb7_en_q) begin
					pb7_state_d = 1'b0;
				end
			end
			OP_START_T2: begin
				t2_count_d = count_t'(cmd_s1.start_value);
				t2_armed_d = 1'b1;
			end
			default: ;
		endcase
	end

	res_word_t res_d;
	always_comb begin
		res_d.pb7_level   = pb7_state_d;
		res_d.t1_fired    = t1_fire;
		res_d.t2_fired    = t2_fire;
		res_d.vsync_pulse = vs_hit && tick_op;
		res_d.frame_due   = fd_hit && tick_op;
		res_d.t1_now      = VALUE_W'(t1_count_d);
		res_d.t2_now      = VALUE_W'(t2_count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_carry_q <= 1'b0;
			t1_count_q   <= '0;
			t2_count_q   <= '0;
			pb7_armed_q  <= 1'b0;
			pb7_state_q  <= 1'b0;
			t2_armed_q   <= 1'b0;
		end else if (proc) begin
			tick_carry_q <= tick_carry_d;
			t1_count_q   <= t1_count_d;
			t2_count_q   <= t2_count_d;
			pb7_armed_q  <= pb7_armed_d;
			pb7_state_q  <= pb7_state_d;
			t2_armed_q   <= t2_armed_d;
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (cmd.ready) begin
				v_s1 <= cmd.valid;
			end
			if (advance) begin
				v_s2 <= v_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.data;
		end
		if (proc) begin
			res_s2 <= res_d;
		end
	end

	// a start word never reports a fire, sync or frame flag
	a_start_no_flags: assert property (@(posedge clk) disable iff (!arst_n)
		proc && !tick_op |=> !res_s2.t1_fired && !res_s2.t2_fired &&
			!res_s2.vsync_pulse && !res_s2.frame_due)
		else $error("start word produced a flag");

	// timer two holds its count in pulse-count mode
	a_t2_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		proc && tick_op && t2_pulse_q |=> $stable(t2_count_q))
		else $error("timer two moved in pulse-count mode");

	// timer two fires once: arming is gone when a fire is shown
	a_t2_disarm: assert property (@(posedge clk) disable iff (!arst_n)
		proc |=> !res_s2.t2_fired || !t2_armed_q)
		else $error("timer two still armed after fire");

	// one-shot timer one drops its PB7 arm after a fire
	a_pb7_oneshot: assert property (@(posedge clk) disable iff (!arst_n)
		proc && tick_op && t1_zero && !t1_free_run_q |=> !pb7_armed_q)
		else $error("one-shot PB7 still armed after fire");

	// result flags only change with a new result word
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!proc |=> $stable(res_s2) || !v_s2)
		else $error("result changed without processing");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the dual VIA timer block: directed table, random traffic, stalls.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import vdtt_pkg::*;

	// Codes the block has no use for; both must be ignored.
	localparam logic [1:0]           OP_UNUSED  = 2'd3;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// Idle-cycle limit for the watchdog. Slowest correct stretch: the receiver hold
	// (HOLD_CYCLES) plus the longest sender gap and the block's latency.
	localparam int IDLE_LIMIT  = 1000;
	localparam int HOLD_CYCLES = 150;
	localparam int TAIL_CYCLES = 8;

	// One row of the directed table: the command word, and where typed in,
	// the status word it must produce.
	typedef struct packed {
		cmd_word_t w;
		logic      typed;
		res_word_t r;
	} drow_t;

	// One full set of register values.
	typedef struct packed {
		logic [15:0] latch;
		logic [15:0] free_run;
		logic [15:0] pb7_en;
		logic [15:0] pulse;
		logic [15:0] vsync;
		logic [15:0] frame;
	} cfg_set_t;

	logic clk;
	logic arst_n;

	vdtt_cmd_if cmd_ch ();
	vdtt_res_if res_ch ();
	vdtt_cfg_if cfg_ch ();

	via_dual_timer_tick uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Timer model: own copy of registers and state, reset values.
	// ------------------------------------------------------------------
	logic [VALUE_W-1:0]  latch_val  = T1_LATCH_RST;
	logic                free_run   = 1'b0;
	logic                pb7_en     = 1'b0;
	logic                t2_frozen  = 1'b0;
	logic [PERIOD_W-1:0] vsync_per  = VSYNC_PERIOD_RST;
	logic [PERIOD_W-1:0] frame_per  = FRAME_PERIOD_RST;

	logic                tick_odd   = 1'b0;
	count_t              t1_cnt     = '0;
	count_t              t2_cnt     = '0;
	logic                pb7_live   = 1'b0;
	logic                pb7_out    = 1'b0;
	logic                t2_live    = 1'b0;
	logic [FILL_W-1:0]   vsync_acc  = '0;
	logic [FILL_W-1:0]   frame_acc  = '0;

	res_word_t status_due [$];  // status words still owed by the block
	int        errors     = 0;
	int        words_in   = 0;
	bit        rush       = 1'b0;  // sender runs gapless, receiver holds off once
	bit        send_calm  = 1'b0;

	// Accumulate adapter ticks into a 17-bit period counter.
	// Returns {hit, new count}; a zero period hits on every batch.
	function automatic logic [FILL_W:0] advance_period(logic [FILL_W-1:0] acc,
			logic [PERIOD_W-1:0] per, logic [7:0] half);
		logic [FILL_W-1:0] c;
		c = acc + FILL_W'(half);
		if (c >= FILL_W'(per))
			return {1'b1, c - FILL_W'(per)};
		return {1'b0, c};
	endfunction

	function automatic logic at_or_below_zero(count_t c);
		return (c == '0) || c[CNT_W-1];
	endfunction

	function automatic res_word_t advance_timers(cmd_word_t w);
		logic [8:0]        sum;
		logic [7:0]        half;
		logic [FILL_W:0]   step;
		res_word_t         r;
		r = '0;
		case (w.operation)
			OP_TICK: begin
				// halve the CPU ticks, odd tick carries into next batch
				sum      = {1'b0, w.cpu_ticks} + {8'd0, tick_odd};
				half     = sum[8:1];
				tick_odd = sum[0];

				step          = advance_period(vsync_acc, vsync_per, half);
				r.vsync_pulse = step[FILL_W];
				vsync_acc     = step[FILL_W-1:0];
				step          = advance_period(frame_acc, frame_per, half);
				r.frame_due   = step[FILL_W];
				frame_acc     = step[FILL_W-1:0];

				t1_cnt = t1_cnt - count_t'(half);
				if (at_or_below_zero(t1_cnt)) begin
					if (pb7_live) begin
						if (free_run) begin
							pb7_out = ~pb7_out;
						end else begin
							pb7_out  = 1'b1;
							pb7_live = 1'b0;
						end
					end
					if (free_run)
						t1_cnt = t1_cnt + count_t'(latch_val);
					else
						t1_cnt = count_t'(t1_cnt[COUNTER_BITS-1:0]);
					r.t1_fired = 1'b1;
				end

				if (!t2_frozen) begin
					t2_cnt = t2_cnt - count_t'(half);
					if (at_or_below_zero(t2_cnt)) begin
						if (t2_live) begin
							r.t2_fired = 1'b1;
							t2_live    = 1'b0;
						end
						t2_cnt = count_t'(t2_cnt[COUNTER_BITS-1:0]);
					end
				end
			end
			OP_START_T1: begin
				t1_cnt   = count_t'(w.start_value);
				pb7_live = pb7_en;
				if (pb7_en)
					pb7_out = 1'b0;
			end
			OP_START_T2: begin
				t2_cnt  = count_t'(w.start_value);
				t2_live = 1'b1;
			end
			default: ;  // unused code: state untouched, flags stay low
		endcase
		r.pb7_level = pb7_out;
		r.t1_now    = t1_cnt[VALUE_W-1:0];
		r.t2_now    = t2_cnt[VALUE_W-1:0];
		return r;
	endfunction

	function automatic void apply_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_T1_LATCH:     latch_val = val;
			REG_T1_FREE_RUN:  free_run  = val[0];
			REG_T1_PB7_EN:    pb7_en    = val[0];
			REG_T2_PULSE:     t2_frozen = val[0];
			REG_VSYNC_PERIOD: vsync_per = val;
			REG_FRAME_PERIOD: frame_per = val;
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly back-to-back or short gaps, now and then a long one.
	function automatic int pick_gap(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [15:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 16'($urandom_range(0, 400));
		if (r < 70)
			return 16'($urandom_range(0, 4000));
		if (r < 90)
			return 16'($urandom);
		if (r < 95)
			return 16'h0000;
		return 16'hffff;
	endfunction

	// Tick batches dominate; starts are frequent enough, with small loads,
	// that both timers actually reach zero.
	function automatic cmd_word_t random_cmd();
		cmd_word_t w;
		int        r;
		r             = $urandom_range(0, 99);
		w.cpu_ticks   = 8'($urandom);
		w.start_value = 16'($urandom);
		if (r < 70) begin
			w.operation = OP_TICK;
			r = $urandom_range(0, 9);
			if (r == 0)
				w.cpu_ticks = 8'h00;
			else if (r == 1)
				w.cpu_ticks = 8'hff;
		end else if (r < 83) begin
			w.operation   = OP_START_T1;
			w.start_value = pick_value();
		end else if (r < 96) begin
			w.operation   = OP_START_T2;
			w.start_value = pick_value();
		end else begin
			w.operation = OP_UNUSED;
		end
		return w;
	endfunction

	function automatic cfg_set_t random_set();
		cfg_set_t s;
		s.latch    = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 2000)) : 16'($urandom);
		s.free_run = 16'($urandom);
		s.pb7_en   = 16'($urandom);
		s.pulse    = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'h0000;
		s.vsync    = 16'($urandom_range(1, 3000));
		s.frame    = 16'($urandom_range(1, 6000));
		return s;
	endfunction

	function automatic drow_t go(logic [1:0] op, logic [7:0] ticks, logic [15:0] sv);
		return '{w: '{operation: op, cpu_ticks: ticks, start_value: sv}, typed: 1'b0, r: '0};
	endfunction

	function automatic drow_t go_exp(logic [1:0] op, logic [7:0] ticks, logic [15:0] sv,
			logic pb7, logic t1f, logic t2f, logic vs, logic fd,
			logic [15:0] t1, logic [15:0] t2);
		drow_t d;
		d       = go(op, ticks, sv);
		d.typed = 1'b1;
		d.r     = '{pb7_level: pb7, t1_fired: t1f, t2_fired: t2f, vsync_pulse: vs,
			frame_due: fd, t1_now: t1, t2_now: t2};
		return d;
	endfunction

	// Offer one command word; on acceptance the model advances and the
	// expected status is queued. valid stays high when no gap follows.
	task automatic offer(drow_t d);
		res_word_t got;
		int        gap;
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= d.w;
		do @(posedge clk); while (!cmd_ch.ready);
		got = advance_timers(d.w);
		status_due.push_back(d.typed ? d.r : got);
		words_in++;
		if (words_in % 40 == 0)
			send_calm = ($urandom_range(0, 2) == 0);
		gap = rush ? 0 : pick_gap(send_calm);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic random_burst(int n, int rush_n);
		for (int i = 0; i < n; i++) begin
			rush = (i < rush_n);
			offer('{w: random_cmd(), typed: 1'b0, r: '0});
		end
		rush = 1'b0;
	endtask

	// Lower valid and wait until every status word is back.
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (status_due.size() != 0);
	endtask

	// Register write; valid is left high so writes can run back to back.
	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= '{index: idx, value: val};
		do @(posedge clk); while (!cfg_ch.ready);
		apply_reg(idx, val);
	endtask

	task automatic write_set(cfg_set_t s, bit poke_unused);
		write_reg(REG_T1_LATCH,     s.latch);
		write_reg(REG_T1_FREE_RUN,  s.free_run);
		write_reg(REG_T1_PB7_EN,    s.pb7_en);
		write_reg(REG_T2_PULSE,     s.pulse);
		write_reg(REG_VSYNC_PERIOD, s.vsync);
		write_reg(REG_FRAME_PERIOD, s.frame);
		if (poke_unused)
			write_reg(REG_UNUSED, 16'hffff);
		cfg_ch.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	drow_t    plan [21];
	cfg_set_t sets [7];

	initial begin
		arst_n       <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.data  <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data  <= '0;

		// Directed table, run at reset settings (one-shot, PB7 off,
		// periods 20000/40000). Typed rows follow straight from reset state.
		plan = '{
			// zero ticks on zero counters: timer one fires, timer two unarmed
			go_exp(OP_TICK,      8'd0,   16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
				16'h0000, 16'h0000),
			// 255 ticks: 127 adapter ticks, carry left; one-shot wraps to 16 bits
			go_exp(OP_TICK,      8'd255, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
				16'hff81, 16'hff81),
			go_exp(OP_START_T2,  8'd0,   16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
				16'hff81, 16'h0000),
			// carry plus one tick gives one adapter tick; armed timer two fires
			go_exp(OP_TICK,      8'd1,   16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
				16'hff80, 16'hffff),
			go    (OP_TICK,      8'd0,   16'h0000),
			go_exp(OP_START_T1,  8'hff,  16'hffff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
				16'hffff, 16'hffff),
			go    (OP_START_T2,  8'h00,  16'h0001),
			go    (OP_TICK,      8'd2,   16'h0000),
			// timer two sits at zero, no longer armed: no second fire
			go    (OP_TICK,      8'd0,   16'hffff),
			go    (OP_UNUSED,    8'hff,  16'hffff),
			go    (OP_UNUSED,    8'h00,  16'h0000),
			// timer one at zero keeps firing on empty batches
			go    (OP_START_T1,  8'h00,  16'h0000),
			go    (OP_TICK,      8'd0,   16'h0000),
			go    (OP_TICK,      8'd0,   16'h0000),
			go    (OP_TICK,      8'haa,  16'h5555),
			go    (OP_TICK,      8'h55,  16'haaaa),
			go    (OP_START_T2,  8'h55,  16'h8000),
			go    (OP_START_T1,  8'haa,  16'h7fff),
			go    (OP_TICK,      8'd254, 16'h0000),
			go    (OP_TICK,      8'd255, 16'h0000),
			go    (OP_TICK,      8'd1,   16'h0000)
		};

		// Register settings per phase; the opening phase runs at reset values, sets[0] is written last.
		sets[1] = '{latch: 16'h0000, free_run: 16'h0001, pb7_en: 16'h0001,
			pulse: 16'h0000, vsync: 16'h0001, frame: 16'hffff};
		sets[2] = '{latch: 16'hffff, free_run: 16'h0000, pb7_en: 16'h0001,
			pulse: 16'h0001, vsync: 16'hffff, frame: 16'h0001};
		// zero periods: pulse and due flag on every batch
		sets[3] = '{latch: 16'd300, free_run: 16'h0001, pb7_en: 16'h0001,
			pulse: 16'h0000, vsync: 16'h0000, frame: 16'h0000};
		sets[4] = '{latch: 16'd50, free_run: 16'h0001, pb7_en: 16'h0000,
			pulse: 16'h0000, vsync: 16'd500, frame: 16'd777};
		sets[5] = random_set();
		sets[6] = random_set();
		// upper bits set on the one-bit registers must not matter
		sets[0] = '{latch: 16'd1000, free_run: 16'hfffe, pb7_en: 16'hffff,
			pulse: 16'hfffe, vsync: VSYNC_PERIOD_RST, frame: FRAME_PERIOD_RST};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			offer(plan[i]);
		random_burst(150, 0);

		for (int p = 1; p <= 7; p++) begin
			settle();
			write_set(sets[p % 7], p == 1);
			// phase 2 opens with a gapless stretch while the receiver holds off
			random_burst(125, (p == 2) ? 60 : 0);
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: random stalls, calm stretches, one long hold-off
	// ------------------------------------------------------------------
	initial begin
		int  stall_left;
		int  cycles;
		bit  calm;
		bit  held_off;
		stall_left = 0;
		cycles     = 0;
		calm       = 1'b0;
		held_off   = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rush && !held_off) begin
				held_off = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			cycles++;
			if (cycles % 40 == 0)
				calm = ($urandom_range(0, 2) == 0);
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap(calm);
			end
		end
	end

	// ------------------------------------------------------------------
	// Status checker
	// ------------------------------------------------------------------
	function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		res_word_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (status_due.size() == 0) begin
				$error("status word %0h with nothing expected", res_ch.data);
				errors++;
			end else begin
				want = status_due.pop_front();
				check_field("pb7_level",   16'(want.pb7_level),   16'(res_ch.data.pb7_level));
				check_field("t1_fired",    16'(want.t1_fired),    16'(res_ch.data.t1_fired));
				check_field("t2_fired",    16'(want.t2_fired),    16'(res_ch.data.t2_fired));
				check_field("vsync_pulse", 16'(want.vsync_pulse), 16'(res_ch.data.vsync_pulse));
				check_field("frame_due",   16'(want.frame_due),   16'(res_ch.data.frame_due));
				check_field("t1_now",      want.t1_now,           res_ch.data.t1_now);
				check_field("t2_now",      want.t2_now,           res_ch.data.t2_now);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long without any word moving on any channel
	// ------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
